/* rtl/core/rmq_pkg.sv */
`timescale 1ns / 1ps

package rmq_pkg;

    // Quaternion part that takes s/2 directly; the other three come out of the scaler
    typedef enum logic [1:0] {
        SEL_W,
        SEL_X,
        SEL_Y,
        SEL_Z
    } sel_t;

endpackage

/* rtl/core/rmq_prep.sv */
`timescale 1ns / 1ps

module rmq_prep import rmq_pkg::*; #(
    parameter int DW = 20,
    parameter int FB = 16,
    parameter int AW = 24
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 adv,
    input  logic                 in_valid,
    input  logic signed [DW-1:0] m [9],
    output logic                 out_valid,
    output logic signed [AW-1:0] arg,
    output logic signed [DW:0]   d [3],
    output sel_t                 sel
);

    localparam logic [AW-1:0] ONE_A = AW'(64'd1 << FB);

    logic signed [AW-1:0] e [9];
    logic signed [AW-1:0] trace;
    logic                 pos;
    logic                 i1;
    logic                 i2;
    logic signed [AW-1:0] m_ii;
    logic signed [AW-1:0] arg_next;
    logic signed [DW:0]   d_next [3];
    sel_t                 sel_next;
    logic                 valid_reg;
    logic signed [AW-1:0] arg_reg;
    logic signed [DW:0]   d_reg [3];
    sel_t                 sel_reg;

    always_comb
    begin
        for (int n = 0; n < 9; n++)
        begin
            e[n] = AW'(m[n]);
        end
        trace = e[0] + e[4] + e[8];
        pos   = (trace > 0);
        i1    = (m[4] > m[0]);
        m_ii  = i1 ? e[4] : e[0];
        i2    = (e[8] > m_ii);
        if (pos)
        begin
            sel_next  = SEL_W;
            arg_next  = trace + $signed(ONE_A);
            d_next[0] = (DW+1)'(m[7]) - (DW+1)'(m[5]);
            d_next[1] = (DW+1)'(m[2]) - (DW+1)'(m[6]);
            d_next[2] = (DW+1)'(m[3]) - (DW+1)'(m[1]);
        end
        else if (i2)
        begin
            // i = 2, j = 0, k = 1: lanes carry w, x, y
            sel_next  = SEL_Z;
            arg_next  = e[8] - (e[0] + e[4]) + $signed(ONE_A);
            d_next[0] = (DW+1)'(m[3]) - (DW+1)'(m[1]);
            d_next[1] = (DW+1)'(m[2]) + (DW+1)'(m[6]);
            d_next[2] = (DW+1)'(m[5]) + (DW+1)'(m[7]);
        end
        else if (i1)
        begin
            // i = 1, j = 2, k = 0: lanes carry w, x, z
            sel_next  = SEL_Y;
            arg_next  = e[4] - (e[8] + e[0]) + $signed(ONE_A);
            d_next[0] = (DW+1)'(m[2]) - (DW+1)'(m[6]);
            d_next[1] = (DW+1)'(m[1]) + (DW+1)'(m[3]);
            d_next[2] = (DW+1)'(m[7]) + (DW+1)'(m[5]);
        end
        else
        begin
            // i = 0, j = 1, k = 2: lanes carry w, y, z
            sel_next  = SEL_X;
            arg_next  = e[0] - (e[4] + e[8]) + $signed(ONE_A);
            d_next[0] = (DW+1)'(m[7]) - (DW+1)'(m[5]);
            d_next[1] = (DW+1)'(m[3]) + (DW+1)'(m[1]);
            d_next[2] = (DW+1)'(m[6]) + (DW+1)'(m[2]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            arg_reg <= arg_next;
            d_reg   <= d_next;
            sel_reg <= sel_next;
        end
    end

    assign out_valid = valid_reg;
    assign arg       = arg_reg;
    assign d         = d_reg;
    assign sel       = sel_reg;

endmodule

/* rtl/core/rmq_sqrt.sv */
`timescale 1ns / 1ps

module rmq_sqrt #(
    parameter int AW     = 24,
    parameter int FB     = 16,
    parameter int SW     = 19,
    parameter int SIDE_W = 8
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 adv,
    input  logic                 in_valid,
    input  logic signed [AW-1:0] arg,
    input  logic [SIDE_W-1:0]    side_in,
    output logic                 out_valid,
    output logic [SW-1:0]        root,
    output logic [SIDE_W-1:0]    side_out
);

    localparam int RW = 2 * SW;

    logic [RW-1:0]     rad_reg  [SW];
    logic [SW+1:0]     rem_reg  [SW+1];
    logic [SW-1:0]     root_reg [SW+1];
    logic [SIDE_W-1:0] side_reg [SW+1];
    logic              vld_reg  [SW+1];
    logic [RW-1:0]     rad_in;

    // Clamp a non-positive argument to zero, then scale by 2^FB
    always_comb
    begin
        if (arg <= 0)
        begin
            rad_in = '0;
        end
        else
        begin
            rad_in = RW'({arg[AW-2:0], {FB{1'b0}}});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg[0] <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rad_reg[0]  <= rad_in;
            rem_reg[0]  <= '0;
            root_reg[0] <= '0;
            side_reg[0] <= side_in;
        end
    end

    // One result bit per stage: bring down two radicand bits, try (root << 2) | 1
    for (genvar t = 1; t <= SW; t++)
    begin : g_stage
        logic [SW+3:0] rem_x;
        logic [SW+3:0] trial;
        logic          take;

        always_comb
        begin
            rem_x = {rem_reg[t-1], rad_reg[t-1][RW-1:RW-2]};
            trial = (SW+4)'({root_reg[t-1], 2'b01});
            take  = (rem_x >= trial);
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[t] <= 1'b0;
            end
            else if (adv)
            begin
                vld_reg[t] <= vld_reg[t-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rem_reg[t]  <= take ? (SW+2)'(rem_x - trial) : (SW+2)'(rem_x);
                root_reg[t] <= {root_reg[t-1][SW-2:0], take};
                side_reg[t] <= side_reg[t-1];
            end
        end

        if (t < SW)
        begin : g_rad
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    rad_reg[t] <= {rad_reg[t-1][RW-3:0], 2'b00};
                end
            end
        end
    end

    assign out_valid = vld_reg[SW];
    assign root      = root_reg[SW];
    assign side_out  = side_reg[SW];

endmodule

/* rtl/core/rmq_scale.sv */
`timescale 1ns / 1ps

module rmq_scale #(
    parameter int DW     = 20,
    parameter int FB     = 16,
    parameter int SW     = 19,
    parameter int SIDE_W = 22
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 adv,
    input  logic                 in_valid,
    input  logic [SW-1:0]        s,
    input  logic signed [DW:0]   d [3],
    input  logic [SIDE_W-1:0]    side_in,
    output logic                 out_valid,
    output logic signed [DW-1:0] q [3],
    output logic [SIDE_W-1:0]    side_out
);

    // Numerator (|d| << FB) + s over denominator 2s, one quotient bit per stage
    localparam int NW = DW + FB + 2;
    localparam logic [NW-1:0] LIM_P = NW'((64'd1 << (DW - 1)) - 64'd1);
    localparam logic [NW-1:0] LIM_N = NW'(64'd1 << (DW - 1));
    localparam logic [DW-1:0] SMAX  = DW'((64'd1 << (DW - 1)) - 64'd1);
    localparam logic [DW-1:0] SMIN  = DW'(64'd1 << (DW - 1));

    logic [SW:0]       den_reg  [NW+1];
    logic              zero_reg [NW+1];
    logic [SIDE_W-1:0] side_reg [NW+2];
    logic              vld_reg  [NW+2];
    logic [NW-1:0]     nq_reg   [3][NW+1];
    logic [SW:0]       rem_reg  [3][NW+1];
    logic              neg_reg  [3][NW+1];
    logic [DW-1:0]     res_reg  [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int t = 0; t <= NW + 1; t++)
            begin
                vld_reg[t] <= 1'b0;
            end
        end
        else if (adv)
        begin
            vld_reg[0] <= in_valid;
            for (int t = 1; t <= NW + 1; t++)
            begin
                vld_reg[t] <= vld_reg[t-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            den_reg[0]  <= {s, 1'b0};
            zero_reg[0] <= (s == '0);
            side_reg[0] <= side_in;
            for (int t = 1; t <= NW; t++)
            begin
                den_reg[t]  <= den_reg[t-1];
                zero_reg[t] <= zero_reg[t-1];
            end
            for (int t = 1; t <= NW + 1; t++)
            begin
                side_reg[t] <= side_reg[t-1];
            end
        end
    end

    for (genvar l = 0; l < 3; l++)
    begin : g_lane
        logic [DW:0]   mag;
        logic [NW-1:0] sat_q;

        always_comb
        begin
            mag   = d[l][DW] ? (DW+1)'(-d[l]) : (DW+1)'(d[l]);
            sat_q = nq_reg[l][NW];
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                nq_reg[l][0]  <= NW'({mag, {FB{1'b0}}}) + NW'(s);
                rem_reg[l][0] <= '0;
                neg_reg[l][0] <= d[l][DW];
                // Force zero when s was zero, else saturate the magnitude and reapply the sign
                if (zero_reg[NW])
                begin
                    res_reg[l] <= '0;
                end
                else if (neg_reg[l][NW])
                begin
                    res_reg[l] <= (sat_q > LIM_N) ? SMIN : DW'(-sat_q);
                end
                else
                begin
                    res_reg[l] <= (sat_q > LIM_P) ? SMAX : DW'(sat_q);
                end
            end
        end

        for (genvar t = 1; t <= NW; t++)
        begin : g_step
            logic [SW+1:0] rem_x;
            logic          take;

            always_comb
            begin
                rem_x = {rem_reg[l][t-1], nq_reg[l][t-1][NW-1]};
                take  = (rem_x >= (SW+2)'(den_reg[t-1]));
            end

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    rem_reg[l][t] <= take ? (SW+1)'(rem_x - (SW+2)'(den_reg[t-1]))
                                          : (SW+1)'(rem_x);
                    nq_reg[l][t]  <= {nq_reg[l][t-1][NW-2:0], take};
                    neg_reg[l][t] <= neg_reg[l][t-1];
                end
            end
        end

        assign q[l] = $signed(res_reg[l]);
    end

    assign out_valid = vld_reg[NW+1];
    assign side_out  = side_reg[NW+1];

endmodule

/* rtl/core/rotation_matrix_to_quaternion.sv */
`timescale 1ns / 1ps

// Rotation matrix to unit quaternion by Shepperd's method, fully pipelined. A 3x3 matrix
// enters on the slave stream and the quaternion (w, x, y, z) leaves on the master stream,
// all values signed fixed point with FRAC_BITS fraction bits. One transfer is taken every
// clock while s_tready is high. Order of stages: trace and branch select, the square root
// operand register, square root stages giving one bit each, the divider operand register,
// three parallel dividers giving one quotient bit per stage, saturation, output register;
// the bit-serial divider is the deepest section at the default widths. A two-entry output
// stage (output register plus skid) lets the pipe keep accepting while a result waits;
// s_tready drops only when both are full.
// A zero square root gives zero for every part; results saturate to DATA_WIDTH bits.

module rotation_matrix_to_quaternion import rmq_pkg::*; #(
    parameter int DATA_WIDTH = 20,
    parameter int FRAC_BITS  = 16
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     s_tvalid,
    output logic                                     s_tready,
    // m00, m01, m02, m10, m11, m12, m20, m21, m22, zero fill
    input  logic [((9*DATA_WIDTH+7)/8)*8-1:0]        s_tdata,
    output logic                                     m_tvalid,
    input  logic                                     m_tready,
    // quat_w, quat_x, quat_y, quat_z, zero fill
    output logic [((4*DATA_WIDTH+7)/8)*8-1:0]        m_tdata
);

    localparam int DW     = DATA_WIDTH;
    localparam int FB     = FRAC_BITS;
    localparam int OW     = ((4*DW+7)/8)*8;
    localparam int AW     = ((FB + 2 > DW) ? FB + 2 : DW) + 2;
    localparam int RW0    = AW - 1 + FB;
    localparam int SW     = (RW0 + 1) / 2;
    localparam int SIDE_A = 3 * (DW + 1) + 2;
    localparam int SIDE_B = DW + 2;
    localparam logic [SW-2:0] HMAX = (SW - 1 > DW - 1) ? (SW-1)'((64'd1 << (DW-1)) - 64'd1)
                                                       : '1;

    logic                 adv;
    logic signed [DW-1:0] m [9];
    logic                 p_valid;
    logic signed [AW-1:0] p_arg;
    logic signed [DW:0]   p_d [3];
    sel_t                 p_sel;
    logic [SIDE_A-1:0]    sq_side_in;
    logic                 sq_valid;
    logic [SW-1:0]        sq_root;
    logic [SIDE_A-1:0]    sq_side;
    logic signed [DW:0]   sq_d [3];
    logic [SW-2:0]        half_raw;
    logic [DW-1:0]        half;
    logic [SIDE_B-1:0]    sc_side_in;
    logic                 sc_valid;
    logic signed [DW-1:0] sc_q [3];
    logic [SIDE_B-1:0]    sc_side;
    logic [DW-1:0]        sc_half;
    sel_t                 sc_sel;
    logic [OW-1:0]        res_next;
    logic                 ld_out;
    logic                 ld_skid;
    logic                 out_valid_reg;
    logic                 skid_valid_reg;
    logic [OW-1:0]        out_data_reg;
    logic [OW-1:0]        skid_data_reg;

    // Hold the whole pipe only while the skid entry is occupied
    assign adv      = !skid_valid_reg;
    assign s_tready = adv;

    always_comb
    begin
        for (int n = 0; n < 9; n++)
        begin
            m[n] = $signed(s_tdata[n*DW +: DW]);
        end
    end

    rmq_prep #(.DW(DW), .FB(FB), .AW(AW)) u_prep (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (s_tvalid),
        .m         (m),
        .out_valid (p_valid),
        .arg       (p_arg),
        .d         (p_d),
        .sel       (p_sel)
    );

    assign sq_side_in = {p_sel, p_d[2], p_d[1], p_d[0]};

    rmq_sqrt #(.AW(AW), .FB(FB), .SW(SW), .SIDE_W(SIDE_A)) u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (p_valid),
        .arg       (p_arg),
        .side_in   (sq_side_in),
        .out_valid (sq_valid),
        .root      (sq_root),
        .side_out  (sq_side)
    );

    // Unpack the differences and saturate s/2 for the part that takes it directly
    always_comb
    begin
        for (int l = 0; l < 3; l++)
        begin
            sq_d[l] = $signed(sq_side[l*(DW+1) +: DW+1]);
        end
        half_raw = sq_root[SW-1:1];
        if (half_raw > HMAX)
        begin
            half = DW'(HMAX);
        end
        else
        begin
            half = DW'(half_raw);
        end
        sc_side_in = {sq_side[SIDE_A-1 -: 2], half};
    end

    rmq_scale #(.DW(DW), .FB(FB), .SW(SW), .SIDE_W(SIDE_B)) u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (sq_valid),
        .s         (sq_root),
        .d         (sq_d),
        .side_in   (sc_side_in),
        .out_valid (sc_valid),
        .q         (sc_q),
        .side_out  (sc_side)
    );

    // Route the directly taken part and the three scaled lanes into w, x, y, z order
    always_comb
    begin
        sc_half  = sc_side[DW-1:0];
        sc_sel   = sel_t'(sc_side[SIDE_B-1 -: 2]);
        res_next = '0;
        unique case (sc_sel)
            SEL_W:
            begin
                res_next[4*DW-1:0] = {sc_q[2], sc_q[1], sc_q[0], sc_half};
            end
            SEL_X:
            begin
                res_next[4*DW-1:0] = {sc_q[2], sc_q[1], sc_half, sc_q[0]};
            end
            SEL_Y:
            begin
                res_next[4*DW-1:0] = {sc_q[2], sc_half, sc_q[1], sc_q[0]};
            end
            SEL_Z:
            begin
                res_next[4*DW-1:0] = {sc_half, sc_q[2], sc_q[1], sc_q[0]};
            end
            default:
            begin
                res_next = '0;
            end
        endcase
    end

    // Advance a finished result into the output register, or park it in the skid entry
    assign ld_out  = adv && sc_valid && (!out_valid_reg || m_tready);
    assign ld_skid = adv && sc_valid && out_valid_reg && !m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            priority if (skid_valid_reg)
            begin
                if (m_tready)
                begin
                    skid_valid_reg <= 1'b0;
                end
            end
            else if (sc_valid)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= ld_skid;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg && m_tready)
        begin
            out_data_reg <= skid_data_reg;
        end
        else if (ld_out)
        begin
            out_data_reg <= res_next;
        end
        if (ld_skid)
        begin
            skid_data_reg <= res_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry holds data while output register is empty");

    a_stall_keeps_result: assert property (@(posedge clk) disable iff (!rst_n)
        (sc_valid && !adv) |=> sc_valid)
        else $error("pipe result dropped while held");

    a_skid_drains_first: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && m_tready) |=> (out_data_reg == $past(skid_data_reg)))
        else $error("skid entry not moved to output on drain");

endmodule
